// ----- rtl/morse_letter_blink_sequencer_unit_defines.svh -----
// assertion macros shared by the morse letter blink sequencer rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef MORSE_LETTER_BLINK_SEQUENCER_UNIT_DEFINES_SVH
`define MORSE_LETTER_BLINK_SEQUENCER_UNIT_DEFINES_SVH

// condition and consequence in the same cycle
`define MLBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define MLBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mlbs_pkg.sv -----
// package for the morse letter blink sequencer: widths, codes, morse table
// no dependencies
`timescale 1ns / 1ps

package mlbs_pkg;

	localparam int LETTER_W   = 5;
	localparam int LAMP_W     = 2;
	localparam int DUR_W      = 14;
	localparam int BEAT_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam int LETTER_COUNT = 26;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BEAT_MS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAMP_SELECT = 1'd1;

	// register reset values
	localparam logic [BEAT_W-1:0] BEAT_MS_RESET     = 10'd200;
	localparam logic [1:0]        LAMP_SELECT_RESET = 2'd1;

	// lamp drive codes
	localparam logic [LAMP_W-1:0] LAMP_OFF   = 2'd0;
	localparam logic [LAMP_W-1:0] LAMP_RED   = 2'd1;
	localparam logic [LAMP_W-1:0] LAMP_BLUE  = 2'd2;
	localparam logic [LAMP_W-1:0] LAMP_GREEN = 2'd3;

	// segment length codes in beats
	localparam logic [1:0] BEATS_ONE   = 2'd0;
	localparam logic [1:0] BEATS_THREE = 2'd1;
	localparam logic [1:0] BEATS_NINE  = 2'd2;

	typedef struct packed {
		logic [2:0] len;
		logic [3:0] pattern;
	} morse_entry_t;

	// morse patterns, bit i set means element i is a dash
	function automatic morse_entry_t morse_lookup(input logic [LETTER_W-1:0] letter);
		morse_entry_t e;
		unique case (letter)
			5'd0:    e = '{len: 3'd2, pattern: 4'd2};
			5'd1:    e = '{len: 3'd4, pattern: 4'd1};
			5'd2:    e = '{len: 3'd4, pattern: 4'd5};
			5'd3:    e = '{len: 3'd3, pattern: 4'd1};
			5'd4:    e = '{len: 3'd1, pattern: 4'd0};
			5'd5:    e = '{len: 3'd4, pattern: 4'd4};
			5'd6:    e = '{len: 3'd3, pattern: 4'd3};
			5'd7:    e = '{len: 3'd4, pattern: 4'd0};
			5'd8:    e = '{len: 3'd2, pattern: 4'd0};
			5'd9:    e = '{len: 3'd4, pattern: 4'd14};
			5'd10:   e = '{len: 3'd3, pattern: 4'd5};
			5'd11:   e = '{len: 3'd4, pattern: 4'd2};
			5'd12:   e = '{len: 3'd2, pattern: 4'd3};
			5'd13:   e = '{len: 3'd2, pattern: 4'd1};
			5'd14:   e = '{len: 3'd3, pattern: 4'd7};
			5'd15:   e = '{len: 3'd4, pattern: 4'd6};
			5'd16:   e = '{len: 3'd4, pattern: 4'd11};
			5'd17:   e = '{len: 3'd3, pattern: 4'd2};
			5'd18:   e = '{len: 3'd3, pattern: 4'd0};
			5'd19:   e = '{len: 3'd1, pattern: 4'd1};
			5'd20:   e = '{len: 3'd3, pattern: 4'd4};
			5'd21:   e = '{len: 3'd4, pattern: 4'd8};
			5'd22:   e = '{len: 3'd3, pattern: 4'd6};
			5'd23:   e = '{len: 3'd4, pattern: 4'd9};
			5'd24:   e = '{len: 3'd4, pattern: 4'd13};
			5'd25:   e = '{len: 3'd4, pattern: 4'd3};
			default: e = '{len: 3'd0, pattern: 4'd0};
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/mlbs_ifs.sv -----
// handshake interfaces for letters in and lamp segments out
// depends on mlbs_pkg
`timescale 1ns / 1ps

interface mlbs_letter_if;
	logic                          valid;
	logic                          ready;
	logic [mlbs_pkg::LETTER_W-1:0] letter;

	modport source (output valid, output letter, input ready);
	modport sink   (input valid, input letter, output ready);
endinterface

interface mlbs_seg_if;
	logic                        valid;
	logic                        ready;
	logic [mlbs_pkg::LAMP_W-1:0] lamp;
	logic [mlbs_pkg::DUR_W-1:0]  duration_ms;
	logic                        last;

	modport source (output valid, output lamp, output duration_ms, output last, input ready);
	modport sink   (input valid, input lamp, input duration_ms, input last, output ready);
endinterface

// ----- rtl/mlbs_beat_scale.sv -----
// shared shift-add unit: segment length = beats times beat length
// depends on mlbs_pkg
`timescale 1ns / 1ps

module mlbs_beat_scale (
	input  logic [mlbs_pkg::BEAT_W-1:0] beat,
	input  logic [1:0]                  beats,
	output logic [mlbs_pkg::DUR_W-1:0]  duration_ms
);

	logic [mlbs_pkg::DUR_W-1:0] base;
	logic [mlbs_pkg::DUR_W-1:0] addend;

	assign base = mlbs_pkg::DUR_W'(beat);

	// 3 = 1 + 2, 9 = 1 + 8
	always_comb begin
		unique case (beats)
			mlbs_pkg::BEATS_THREE: addend = base << 1;
			mlbs_pkg::BEATS_NINE:  addend = base << 3;
			default:               addend = '0;
		endcase
	end

	assign duration_ms = base + addend;

endmodule

// ----- rtl/morse_letter_blink_sequencer_unit.sv -----
// top level of the morse letter blink sequencer
// depends on mlbs_pkg, mlbs_ifs, mlbs_beat_scale and the assertion macro header
//
//   channel   dir  payload                        transaction
//   letters   in   letter[4:0]                    valid & ready
//   segments  out  lamp[1:0] duration_ms[13:0]    valid & ready
//                  last
//   cfg       in   cfg_index, cfg_data[9:0]       cfg_we
//
// a letter is taken, then one segment is made per cycle that the output
// register is free: 2 x blinks segments (2 to 20)
// letters codes 26..31 are taken and give no segment
// not ready for a new letter until the last segment is in the output register
// a stalled output holds the sequencer, nothing is dropped
// reset clears the sequencer and sets beat_ms 200, lamp_select 1
`timescale 1ns / 1ps

`include "morse_letter_blink_sequencer_unit_defines.svh"

module morse_letter_blink_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mlbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mlbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	mlbs_letter_if.sink                       letters,
	mlbs_seg_if.source                        segments
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ON   = 2'd1;
	localparam logic [1:0] ST_GAP  = 2'd2;
	localparam logic [1:0] ST_TAIL = 2'd3;

	logic [mlbs_pkg::BEAT_W-1:0] beat_q;
	logic [1:0]                  lamp_sel_q;

	logic [1:0]                  state_q;
	logic [3:0]                  pattern_q;
	logic [2:0]                  len_q;
	logic [1:0]                  elem_q;
	logic [1:0]                  blink_q;
	logic [1:0]                  gap_code_q;

	logic                        out_valid_q;
	logic [mlbs_pkg::LAMP_W-1:0] lamp_q;
	logic [mlbs_pkg::DUR_W-1:0]  dur_q;
	logic                        last_q;

	logic [mlbs_pkg::BEAT_W-1:0] beat_eff;
	logic [mlbs_pkg::LAMP_W-1:0] on_lamp;
	logic [1:0]                  beats_sel;
	logic [mlbs_pkg::DUR_W-1:0]  seg_dur;
	logic                        advance;
	logic                        take;
	logic                        letter_ok;
	logic                        is_dash;
	logic                        last_blink;
	logic                        last_elem;
	mlbs_pkg::morse_entry_t      entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q     <= mlbs_pkg::BEAT_MS_RESET;
			lamp_sel_q <= mlbs_pkg::LAMP_SELECT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlbs_pkg::REG_BEAT_MS:     beat_q     <= cfg_data[mlbs_pkg::BEAT_W-1:0];
				mlbs_pkg::REG_LAMP_SELECT: lamp_sel_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// zero beat counts as one, colour select saturates at green
	assign beat_eff = (beat_q == '0) ? mlbs_pkg::BEAT_W'(1) : beat_q;
	assign on_lamp  = (lamp_sel_q >= 2'd2) ? mlbs_pkg::LAMP_GREEN : lamp_sel_q + 2'd1;

	// letter intake
	assign letters.ready = (state_q == ST_IDLE);
	assign take          = letters.valid && letters.ready;
	assign letter_ok     = letters.letter < mlbs_pkg::LETTER_W'(mlbs_pkg::LETTER_COUNT);
	assign entry         = mlbs_pkg::morse_lookup(letters.letter);

	// position within the pattern
	assign is_dash    = pattern_q[elem_q];
	assign last_blink = !is_dash || (blink_q == 2'd2);
	assign last_elem  = ({1'b0, elem_q} == len_q - 3'd1);

	assign advance = (state_q != ST_IDLE) && (!out_valid_q || segments.ready);

	// segment length selection for the shared unit
	always_comb begin
		unique case (state_q)
			ST_GAP:  beats_sel = gap_code_q;
			ST_TAIL: beats_sel = mlbs_pkg::BEATS_NINE;
			default: beats_sel = mlbs_pkg::BEATS_ONE;
		endcase
	end

	mlbs_beat_scale u_scale (
		.beat        (beat_eff),
		.beats       (beats_sel),
		.duration_ms (seg_dur)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pattern_q  <= '0;
			len_q      <= '0;
			elem_q     <= '0;
			blink_q    <= '0;
			gap_code_q <= mlbs_pkg::BEATS_ONE;
		end else if (take) begin
			if (letter_ok) begin
				state_q   <= ST_ON;
				pattern_q <= entry.pattern;
				len_q     <= entry.len;
				elem_q    <= '0;
				blink_q   <= '0;
			end
		end else if (advance) begin
			unique case (state_q)
				ST_ON: begin
					if (!last_blink) begin
						blink_q    <= blink_q + 2'd1;
						gap_code_q <= mlbs_pkg::BEATS_ONE;
						state_q    <= ST_GAP;
					end else if (!last_elem) begin
						elem_q     <= elem_q + 2'd1;
						blink_q    <= '0;
						gap_code_q <= mlbs_pkg::BEATS_THREE;
						state_q    <= ST_GAP;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_GAP:  state_q <= ST_ON;
				ST_TAIL: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (segments.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			lamp_q <= (state_q == ST_ON) ? on_lamp : mlbs_pkg::LAMP_OFF;
			dur_q  <= seg_dur;
			last_q <= (state_q == ST_TAIL);
		end
	end

	assign segments.valid       = out_valid_q;
	assign segments.lamp        = lamp_q;
	assign segments.duration_ms = dur_q;
	assign segments.last        = last_q;

	// checks
	`MLBS_ASSERT_NEXT(a_start_on, take && letter_ok, state_q == ST_ON, "letter did not start")
	`MLBS_ASSERT_NOW(a_last_idle, out_valid_q && last_q, (state_q == ST_IDLE) || (state_q == ST_ON), "sequencer ran past a waiting last segment")
	`MLBS_ASSERT_NOW(a_elem_range, state_q != ST_IDLE, {1'b0, elem_q} < len_q, "element past end")
	`MLBS_ASSERT_NOW(a_on_one_beat, out_valid_q && (lamp_q != mlbs_pkg::LAMP_OFF), dur_q == mlbs_pkg::DUR_W'(beat_eff), "on segment not one beat")

endmodule
